@@ rtl/pdsavg_pkg.sv @@
`timescale 1ns / 1ps

package pdsavg_pkg;

    // Configuration register widths and indexes
    localparam int SRC_WIDTH_W     = 12;
    localparam int SRC_HEIGHT_W    = 13;
    localparam int CHANNEL_COUNT_W = 3;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_HEIGHT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic [SRC_WIDTH_W-1:0]     SRC_WIDTH_RESET     = 12'd2;
    localparam logic [SRC_HEIGHT_W-1:0]    SRC_HEIGHT_RESET    = 13'd2;
    localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RESET = 3'd4;
    localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_MAX         = 3'd4;

    // Channel and sum widths
    localparam int NUM_CHAN = 4;
    localparam int CHAN_W   = 8;
    localparam int PSUM_W   = CHAN_W + 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [CHAN_W-1:0] chan3;
        logic [CHAN_W-1:0] chan2;
        logic [CHAN_W-1:0] chan1;
        logic [CHAN_W-1:0] chan0;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out3;
        logic [CHAN_W-1:0] out2;
        logic [CHAN_W-1:0] out1;
        logic [CHAN_W-1:0] out0;
        logic              row_end;
        logic              frame_end;
    } pixel_out_t;

    // Work for the back end: store a pair sum, or emit a reduced pixel
    typedef enum logic {
        OP_STORE = 1'b0,
        OP_EMIT  = 1'b1
    } line_op_kind_t;

    typedef struct packed {
        line_op_kind_t                   kind;
        logic                            use_line;
        logic                            row_end;
        logic                            frame_end;
        logic [NUM_CHAN-1:0][PSUM_W-1:0] hsum;
    } line_op_t;

endpackage

@@ rtl/pixel_downscale_2x2_average.sv @@
`timescale 1ns / 1ps

// 2x2 box-filter downscaler for a raster pixel stream.
// in_valid/in_ready/in_data: one source pixel per transfer, raster order,
//   channels chan0..chan3 (unused ones are ignored).
// out_valid/out_ready/out_data: one reduced pixel per 2x2 block, rounded
//   mean of the block, row_end/frame_end mark row and image ends.
// cfg_valid/cfg_ready/cfg_index/cfg_data: register writes (0 src_width,
//   1 src_height, 2 channel_count); always ready, write only when idle.
// Throughput: one source pixel per cycle while the queue is not full. Classification runs in the front
//   end, a four-entry queue feeds the back end, which reads or writes the
//   line store and averages in a second stage.
// Path: the source pixel that completes a block passes through the queue,
//   the compute stage registers and the output register.
// Stalls: while out_ready is low the result holds; the compute stage and
//   the queue keep filling and in_ready drops only when the queue is full.
// Reset: counters and handshakes clear, registers return to width 2,
//   height 2, four channels. The line store needs no clearing pass.
module pixel_downscale_2x2_average import pdsavg_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pixel_in_t              in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pixel_out_t             out_data
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int Q_W        = SLOT_W + $bits(line_op_t);

    logic [SRC_WIDTH_W-1:0]     src_width_reg;
    logic [SRC_HEIGHT_W-1:0]    src_height_reg;
    logic [CHANNEL_COUNT_W-1:0] channel_count_reg;

    logic              push_valid, push_ready, pop_valid, pop_ready;
    line_op_t          push_op, pop_op;
    logic [SLOT_W-1:0] push_slot, pop_slot;
    logic [Q_W-1:0]    pop_word;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg     <= SRC_WIDTH_RESET;
            src_height_reg    <= SRC_HEIGHT_RESET;
            channel_count_reg <= CHANNEL_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:     src_width_reg     <= cfg_data[SRC_WIDTH_W-1:0];
                CFG_SRC_HEIGHT:    src_height_reg    <= cfg_data[SRC_HEIGHT_W-1:0];
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHANNEL_COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Front end: raster position, pairing, classification
    pdsavg_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SLOT_W     (SLOT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .push_slot  (push_slot)
    );

    // Queue between the two ends
    pdsavg_fifo #(
        .DATA_W (Q_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_slot, push_op}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_word)
    );

    assign pop_slot = pop_word[Q_W-1 -: SLOT_W];
    assign pop_op   = line_op_t'(pop_word[$bits(line_op_t)-1:0]);

    // Back end: line store and averaging
    pdsavg_back #(
        .LINE_DEPTH (LINE_DEPTH),
        .SLOT_W     (SLOT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .channel_count (channel_count_reg),
        .q_valid       (pop_valid),
        .q_ready       (pop_ready),
        .q_op          (pop_op),
        .q_slot        (pop_slot),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data)
    );

    // The last pixel of the image also closes its output row
    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.frame_end || out_data.row_end))
        else $error("frame_end without row_end");

    // Channels above a single-channel setting read zero
    a_unused_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (channel_count_reg == 3'd1 || channel_count_reg == 3'd0))
        |-> (out_data.out1 == '0 && out_data.out2 == '0 && out_data.out3 == '0))
        else $error("unused channel not zero");

    // Queue never takes an entry while full
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |-> !(in_valid && in_ready))
        else $error("pixel accepted with queue full");

endmodule

@@ rtl/pdsavg_front.sv @@
`timescale 1ns / 1ps

module pdsavg_front import pdsavg_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    parameter int SLOT_W     = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [SRC_WIDTH_W-1:0]  src_width,
    input  logic [SRC_HEIGHT_W-1:0] src_height,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  pixel_in_t               in_data,
    output logic                    push_valid,
    input  logic                    push_ready,
    output line_op_t                push_op,
    output logic [SLOT_W-1:0]       push_slot
);

    localparam int CNT_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RCNT_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WCW    = (CNT_W + 1 > SRC_WIDTH_W) ? CNT_W + 1 : SRC_WIDTH_W;
    localparam int HCW    = (RCNT_W + 1 > SRC_HEIGHT_W) ? RCNT_W + 1 : SRC_HEIGHT_W;

    logic [CNT_W-1:0]                col_reg, col_next;
    logic [RCNT_W-1:0]               row_reg, row_next;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] held_reg, held_next;

    logic [WCW-1:0]                  w_ext, w_eff;
    logic [HCW-1:0]                  h_ext, h_eff;
    logic                            last_col, last_row;
    logic                            accept, hold_only;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] pix;
    logic [NUM_CHAN-1:0][PSUM_W-1:0] hsum;
    logic [CNT_W-1:0]                slot_wide;

    // Geometry saturated into the supported range
    assign w_ext = WCW'(src_width);
    assign h_ext = HCW'(src_height);
    assign w_eff = (w_ext == '0) ? WCW'(1) :
                   ((w_ext > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : w_ext);
    assign h_eff = (h_ext == '0) ? HCW'(1) :
                   ((h_ext > HCW'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : h_ext);

    assign last_col = (WCW'(col_reg) + WCW'(1)) >= w_eff;
    assign last_row = (HCW'(row_reg) + HCW'(1)) >= h_eff;

    assign pix = {in_data.chan3, in_data.chan2, in_data.chan1, in_data.chan0};

    // Horizontal pair sum; a lone last column counts twice
    always_comb
    begin
        for (int j = 0; j < NUM_CHAN; j++)
        begin
            if (col_reg[0])
                hsum[j] = {1'b0, held_reg[j]} + {1'b0, pix[j]};
            else
                hsum[j] = {pix[j], 1'b0};
        end
    end

    assign in_ready  = push_ready;
    assign accept    = in_valid && in_ready;
    assign hold_only = !col_reg[0] && !last_col;

    // Classify the pixel for the back end
    assign slot_wide  = col_reg >> 1;
    assign push_slot  = slot_wide[SLOT_W-1:0];
    assign push_valid = accept && !hold_only;

    always_comb
    begin
        push_op.kind      = (!row_reg[0] && !last_row) ? OP_STORE : OP_EMIT;
        push_op.use_line  = row_reg[0];
        push_op.row_end   = last_col;
        push_op.frame_end = last_col && last_row;
        push_op.hsum      = hsum;
    end

    // Raster position and held even-column pixel
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RCNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
            if (hold_only)
                held_next = pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
        end
    end

endmodule

@@ rtl/pdsavg_fifo.sv @@
`timescale 1ns / 1ps

module pdsavg_fifo import pdsavg_pkg::*; #(
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ rtl/pdsavg_back.sv @@
`timescale 1ns / 1ps

module pdsavg_back import pdsavg_pkg::*; #(
    parameter int LINE_DEPTH = 1024,
    parameter int SLOT_W     = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [CHANNEL_COUNT_W-1:0] channel_count,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  line_op_t                   q_op,
    input  logic [SLOT_W-1:0]          q_slot,
    output logic                       out_valid,
    input  logic                       out_ready,
    output pixel_out_t                 out_data
);

    // Line store of even-row pair sums
    logic [NUM_CHAN*PSUM_W-1:0]      line_mem [LINE_DEPTH];
    logic [NUM_CHAN-1:0][PSUM_W-1:0] line_q_reg;

    logic       a_valid_reg, a_valid_next;
    line_op_t   a_op_reg;
    logic       out_valid_reg, out_valid_next;
    pixel_out_t out_data_reg;

    logic                            a_free, b_free, pop, pop_store, pop_emit;
    logic [CHANNEL_COUNT_W-1:0]      nch_eff;
    logic [NUM_CHAN-1:0][PSUM_W-1:0] upper;
    logic [NUM_CHAN-1:0][PSUM_W:0]   total;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] avg;

    assign b_free    = !out_valid_reg || out_ready;
    assign a_free    = !a_valid_reg || b_free;
    assign q_ready   = (q_op.kind == OP_STORE) || a_free;
    assign pop       = q_valid && q_ready;
    assign pop_store = pop && (q_op.kind == OP_STORE);
    assign pop_emit  = pop && (q_op.kind == OP_EMIT);

    // Store writes and emit reads, in queue order
    always_ff @(posedge clk)
    begin
        if (pop_store)
            line_mem[q_slot] <= q_op.hsum;
        if (pop_emit)
            line_q_reg <= line_mem[q_slot];
    end

    // Compute stage
    assign a_valid_next = pop_emit ? 1'b1 : (b_free ? 1'b0 : a_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop_emit)
            a_op_reg <= q_op;
    end

    // Rounded mean of the 2x2 block, unused channels forced to zero
    assign nch_eff = (channel_count == '0) ? CHANNEL_COUNT_W'(1) :
                     ((channel_count > CHANNEL_MAX) ? CHANNEL_MAX : channel_count);

    always_comb
    begin
        for (int j = 0; j < NUM_CHAN; j++)
        begin
            upper[j] = a_op_reg.use_line ? line_q_reg[j] : a_op_reg.hsum[j];
            total[j] = {1'b0, upper[j]} + {1'b0, a_op_reg.hsum[j]} + (PSUM_W + 1)'(2);
            if (CHANNEL_COUNT_W'(j) < nch_eff)
                avg[j] = total[j][PSUM_W:2];
            else
                avg[j] = '0;
        end
    end

    // Output register
    assign out_valid_next = b_free ? a_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (b_free && a_valid_reg)
        begin
            out_data_reg.out0      <= avg[0];
            out_data_reg.out1      <= avg[1];
            out_data_reg.out2      <= avg[2];
            out_data_reg.out3      <= avg[3];
            out_data_reg.row_end   <= a_op_reg.row_end;
            out_data_reg.frame_end <= a_op_reg.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ dv/tb_pixel_downscale_2x2_average.sv @@
`timescale 1ns / 1ps

module tb_pixel_downscale_2x2_average;
    import pdsavg_pkg::*;

    localparam int MAX_W        = 2048;
    localparam int MAX_H        = 4096;
    localparam int LINE_SLOTS   = (MAX_W + 1) / 2;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 1850;

    // Index past the last register; the block must ignore it
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    // Box-filter predictor with its own copy of registers, line store and raster position
    class downscale_scoreboard;
        logic [SRC_WIDTH_W-1:0]     width_reg;
        logic [SRC_HEIGHT_W-1:0]    height_reg;
        logic [CHANNEL_COUNT_W-1:0] chan_reg;
        logic [PSUM_W-1:0]          pair_line [LINE_SLOTS][NUM_CHAN];
        logic [CHAN_W-1:0]          held [NUM_CHAN];
        int unsigned                col;
        int unsigned                row;
        pixel_out_t                 reduced_due [$];
        int                         mismatch_count;

        function new();
            width_reg      = SRC_WIDTH_RESET;
            height_reg     = SRC_HEIGHT_RESET;
            chan_reg       = CHANNEL_COUNT_RESET;
            col            = 0;
            row            = 0;
            mismatch_count = 0;
            for (int j = 0; j < NUM_CHAN; j++)
            begin
                held[j] = '0;
            end
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > MAX_W)
                return MAX_W;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0)
                return 1;
            if (height_reg > MAX_H)
                return MAX_H;
            return height_reg;
        endfunction

        function int unsigned eff_chans();
            if (chan_reg == 0)
                return 1;
            if (chan_reg > CHANNEL_MAX)
                return CHANNEL_MAX;
            return chan_reg;
        endfunction

        function void apply_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SRC_WIDTH:     width_reg  = data[SRC_WIDTH_W-1:0];
                CFG_SRC_HEIGHT:    height_reg = data[SRC_HEIGHT_W-1:0];
                CFG_CHANNEL_COUNT: chan_reg   = data[CHANNEL_COUNT_W-1:0];
                default:           ;
            endcase
        endfunction

        // Source pixels still to come before the raster position wraps to 0,0
        function int unsigned frame_items_left();
            int unsigned w;
            int unsigned h;
            int unsigned n;
            w = eff_width();
            h = eff_height();
            n = (col + 1 >= w) ? 1 : w - col;
            if (row + 1 < h)
                n += (h - 1 - row) * w;
            return n;
        endfunction

        // One accepted source pixel: hold, store a pair sum, or predict a reduced pixel
        function void accept_pixel(pixel_in_t p);
            int unsigned w;
            int unsigned h;
            int unsigned nch;
            int unsigned c;
            int unsigned r;
            int unsigned slot;
            int unsigned upper;
            int unsigned v;
            int unsigned hsum [NUM_CHAN];
            logic [CHAN_W-1:0] pix [NUM_CHAN];
            logic [CHAN_W-1:0] avg [NUM_CHAN];
            bit last_col;
            bit last_row;
            pixel_out_t o;

            w        = eff_width();
            h        = eff_height();
            nch      = eff_chans();
            c        = col;
            r        = row;
            last_col = (c + 1 >= w);
            last_row = (r + 1 >= h);
            slot     = (c >> 1) % LINE_SLOTS;
            for (int j = 0; j < NUM_CHAN; j++)
            begin
                pix[j] = p[CHAN_W*j +: CHAN_W];
            end

            // raster position, wrapping past the last column / row
            if (last_col)
            begin
                col = 0;
                row = last_row ? 0 : r + 1;
            end
            else
            begin
                col = c + 1;
            end

            // even column with a partner to come
            if (c % 2 == 0 && !last_col)
            begin
                for (int j = 0; j < NUM_CHAN; j++)
                begin
                    held[j] = pix[j];
                end
                return;
            end

            // horizontal pair sum; a lone last column counts twice
            for (int j = 0; j < NUM_CHAN; j++)
            begin
                hsum[j] = (c % 2 == 1) ? held[j] + pix[j] : 2 * pix[j];
            end

            // even row with an odd row below: park the sums in the line store
            if (r % 2 == 0 && !last_row)
            begin
                for (int j = 0; j < NUM_CHAN; j++)
                begin
                    pair_line[slot][j] = hsum[j][PSUM_W-1:0];
                end
                return;
            end

            for (int j = 0; j < NUM_CHAN; j++)
            begin
                upper  = (r % 2 == 1) ? pair_line[slot][j] : hsum[j];
                v      = (upper + hsum[j] + 2) >> 2;
                avg[j] = (j < nch) ? v[CHAN_W-1:0] : '0;
            end
            o.out0      = avg[0];
            o.out1      = avg[1];
            o.out2      = avg[2];
            o.out3      = avg[3];
            o.row_end   = last_col;
            o.frame_end = last_col && last_row;
            reduced_due.push_back(o);
        endfunction

        function string fmt(pixel_out_t o);
            return $sformatf("ch=%02h %02h %02h %02h row_end=%0b frame_end=%0b",
                             o.out0, o.out1, o.out2, o.out3, o.row_end, o.frame_end);
        endfunction

        function void report(string msg);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function void check_result(pixel_out_t got);
            pixel_out_t want;
            if (reduced_due.size() == 0)
            begin
                report({"reduced pixel with none due: ", fmt(got)});
                return;
            end
            want = reduced_due.pop_front();
            if (got.out0 !== want.out0 || got.out1 !== want.out1 ||
                got.out2 !== want.out2 || got.out3 !== want.out3 ||
                got.row_end !== want.row_end || got.frame_end !== want.frame_end)
                report({"expected ", fmt(want), " got ", fmt(got)});
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    pixel_in_t              in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    pixel_out_t             out_data;

    bit src_idling = 1'b0;
    bit snk_idling = 1'b0;
    downscale_scoreboard sb;

    pixel_downscale_2x2_average #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pixel with extremes mixed in on every channel
    function automatic pixel_in_t random_pixel();
        pixel_in_t p;
        for (int j = 0; j < NUM_CHAN; j++)
        begin
            case ($urandom_range(0, 9))
                0:       p[CHAN_W*j +: CHAN_W] = '0;
                1:       p[CHAN_W*j +: CHAN_W] = '1;
                default: p[CHAN_W*j +: CHAN_W] = CHAN_W'($urandom_range(0, 255));
            endcase
        end
        return p;
    endfunction

    // One source transfer, with an optional gap ahead of it
    task automatic send_pixel(input pixel_in_t p);
        int unsigned gap;
        gap = 0;
        if (src_idling && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 14);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge clk); while (!in_ready);
        sb.accept_pixel(p);
    endtask

    // Register write; the caller drops cfg_valid after the last one
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.apply_register(idx, data);
    endtask

    // Stop the source, wait for every due pixel, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.reduced_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: check each transfer, stall in random bursts
    initial
    begin : result_sink
        int unsigned run;
        run = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (run != 0)
            begin
                run--;
            end
            else if (snk_idling && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                run = $urandom_range(1, 14) - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                run = $urandom_range(0, 19);
            end
        end
    end

    // Ends the run when no transfer of any kind happens for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned random_sent;
        int unsigned n;
        int unsigned left;
        int unsigned cap;
        logic [CFG_DATA_W-1:0] d;

        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale and mixed blocks at the reset geometry
        repeat (4) send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00FF_00FF);
        send_pixel(32'hFF00_FF00);
        send_pixel(32'h0101_0101);
        send_pixel(32'h0202_0202);
        settle();

        // odd last column and row; zero channel count acts as one channel
        write_reg(CFG_SRC_WIDTH, 13'd3);
        write_reg(CFG_SRC_HEIGHT, 13'd3);
        write_reg(CFG_CHANNEL_COUNT, 13'd0);
        cfg_valid <= 1'b0;
        repeat (9) send_pixel(random_pixel());
        settle();

        // zero sizes clamp to 1x1, oversize channel count, write to an unused index
        write_reg(CFG_SRC_WIDTH, 13'h1000);
        write_reg(CFG_SRC_HEIGHT, 13'h0000);
        write_reg(CFG_CHANNEL_COUNT, 13'h1FFF);
        write_reg(CFG_SPARE_INDEX, 13'h1FFF);
        cfg_valid <= 1'b0;
        send_pixel(random_pixel());
        settle();

        // oversize geometry, then shrink mid-frame so the position lands past the end
        write_reg(CFG_SRC_WIDTH, 13'h0FFF);
        write_reg(CFG_SRC_HEIGHT, 13'h1FFF);
        write_reg(CFG_CHANNEL_COUNT, 13'd5);
        cfg_valid <= 1'b0;
        repeat (3) send_pixel(random_pixel());
        settle();
        write_reg(CFG_SRC_WIDTH, 13'd1);
        cfg_valid <= 1'b0;
        send_pixel(random_pixel());
        settle();
        write_reg(CFG_SRC_HEIGHT, 13'd1);
        cfg_valid <= 1'b0;
        send_pixel(random_pixel());

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            if (random_sent >= RANDOM_ITEMS * 17 / 20)
            begin
                src_idling = 1'b0;
                snk_idling = 1'b0;
            end
            else
            begin
                src_idling = ($urandom_range(0, 3) != 0);
                snk_idling = ($urandom_range(0, 3) != 0);
            end

            if (sb.col == 0 && sb.row == 0)
            begin
                // new frame: any geometry, mostly small
                if ($urandom_range(0, 9) < 7)
                begin
                    case ($urandom_range(0, 9))
                        0:       d = '0;
                        1:       d = 13'h0FFF;
                        2:       d = CFG_DATA_W'(MAX_W);
                        3:       d = CFG_DATA_W'($urandom_range(0, 8191));
                        default: d = CFG_DATA_W'($urandom_range(1, 12) +
                                                 ($urandom_range(0, 1) << 12));
                    endcase
                    write_reg(CFG_SRC_WIDTH, d);
                end
                if ($urandom_range(0, 9) < 7)
                begin
                    case ($urandom_range(0, 9))
                        0:       d = '0;
                        1:       d = 13'h1FFF;
                        2:       d = CFG_DATA_W'(MAX_H);
                        3:       d = CFG_DATA_W'($urandom_range(0, 8191));
                        default: d = CFG_DATA_W'($urandom_range(1, 8));
                    endcase
                    write_reg(CFG_SRC_HEIGHT, d);
                end
                if ($urandom_range(0, 9) < 7)
                    write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(0, 8191)));
                if ($urandom_range(0, 19) == 0)
                    write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom_range(0, 8191)));
            end
            else
            begin
                // mid-frame: width may only grow at the start of an even row, height
                // only at a row start or inside an odd row, so no unwritten slot is read
                if ($urandom_range(0, 1) == 0)
                    write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(0, 8191)));
                if (sb.eff_width() > 12 || $urandom_range(0, 2) == 0)
                begin
                    if (sb.col == 0 && sb.row % 2 == 0 && $urandom_range(0, 1) == 0)
                    begin
                        write_reg(CFG_SRC_WIDTH, CFG_DATA_W'($urandom_range(1, 12)));
                    end
                    else
                    begin
                        cap = (sb.eff_width() < 12) ? sb.eff_width() : 12;
                        write_reg(CFG_SRC_WIDTH, CFG_DATA_W'($urandom_range(0, cap)));
                    end
                end
                if ((sb.col == 0 || sb.row % 2 == 1) &&
                    (sb.frame_items_left() > 300 || $urandom_range(0, 2) == 0))
                    write_reg(CFG_SRC_HEIGHT, CFG_DATA_W'($urandom_range(0, sb.row + 4)));
            end
            cfg_valid <= 1'b0;

            // mostly whole frames; sometimes a piece so the next write lands mid-frame
            left = sb.frame_items_left();
            if (left <= 150 && $urandom_range(0, 4) != 0)
                n = left;
            else
                n = $urandom_range(1, (left < 40) ? left : 40);
            repeat (n) send_pixel(random_pixel());
            random_sent += n;
        end
        settle();

        if (sb.mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
